FILE: hdl/mrpt_pkg.sv
// Shared constants and types for the Miller-Rabin primality test block.
package mrpt_pkg;

  localparam int NUM_WIDTH  = 32;
  localparam int MAX_ROUNDS = 64;
  localparam int RND_WIDTH  = 31;
  localparam int CNT_WIDTH  = 7;
  localparam int BIT_IDX_W  = $clog2(NUM_WIDTH);
  localparam int RND_IDX_W  = $clog2(RND_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_TZ,
    S_P_SQ,
    S_P_SQW,
    S_P_ML,
    S_P_MLW,
    S_CHK,
    S_L_SQ,
    S_L_SQW,
    S_FIN
  } state_t;

  typedef struct packed {
    logic                 done;
    logic [NUM_WIDTH-1:0] prod;
  } mm_rsp_t;

endpackage

FILE: hdl/mrpt_mulmod.sv
// Bit-serial modular multiplier: double-and-add with one reduce per cycle.
module mrpt_mulmod
  import mrpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] op_a,
  input  logic [NUM_WIDTH-1:0] op_b,
  input  logic [NUM_WIDTH-1:0] modulus,
  output mm_rsp_t              rsp
);

  logic                 busy_r, busy_nxt;
  logic                 phase_r, phase_nxt;
  logic                 done_r, done_nxt;
  logic [BIT_IDX_W-1:0] idx_r, idx_nxt;
  logic [NUM_WIDTH-1:0] acc_r, acc_nxt;
  logic [NUM_WIDTH-1:0] a_r, a_nxt;
  logic [NUM_WIDTH-1:0] b_r, b_nxt;
  logic [NUM_WIDTH-1:0] n_r, n_nxt;
  logic [NUM_WIDTH:0]   t;
  logic [NUM_WIDTH:0]   t_red;
  logic                 last;

  always_comb begin
    t     = phase_r ? ({1'b0, acc_r} + {1'b0, a_r}) : {acc_r, 1'b0};
    t_red = (t >= {1'b0, n_r}) ? (t - {1'b0, n_r}) : t;
    last  = (idx_r == '0);
  end

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    n_nxt     = n_r;
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      idx_nxt   = BIT_IDX_W'(NUM_WIDTH - 1);
      acc_nxt   = '0;
      a_nxt     = op_a;
      b_nxt     = op_b;
      n_nxt     = modulus;
    end else if (busy_r) begin
      acc_nxt = t_red[NUM_WIDTH-1:0];
      if (!phase_r && b_r[idx_r]) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        if (last) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    idx_r <= idx_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    n_r   <= n_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

FILE: hdl/miller_rabin_primality_test.sv
// Top level of the Miller-Rabin primality test: round sequencer and verdict.
//
// channel | ports                                    | direction
// in      | in_valid in_stall in_candidate in_random_value | word in, one round
// out     | out_valid out_stall out_probably_prime   | word out, one per group
// cfg     | cfg_we cfg_wdata                         | rounds register
//
// One round: accept, remainder, trailing-zero shift, check and finish steps, plus
// the modular multiplies (start, a pass over each multiplier bit with an extra add
// step per set bit, done); up to 63 multiplies per round.
// Trivial candidates skip to the finish step. in_stall is high while a round runs.
// Synchronous active-low reset; rounds resets to 1, counters to zero.
// A stalled verdict holds every round in its finish step until it is taken.
module miller_rabin_primality_test
  import mrpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_candidate,
  input  logic [RND_WIDTH-1:0] in_random_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_probably_prime,
  input  logic                 cfg_we,
  input  logic [CNT_WIDTH-1:0] cfg_wdata
);

  state_t               state_r, state_nxt;
  logic [NUM_WIDTH-1:0] n_r, n_nxt;
  logic [RND_WIDTH-1:0] rnd_r, rnd_nxt;
  logic [NUM_WIDTH-1:0] rem_r, rem_nxt;
  logic [RND_IDX_W-1:0] ridx_r, ridx_nxt;
  logic [NUM_WIDTH-1:0] d_r, d_nxt;
  logic [BIT_IDX_W-1:0] s_r, s_nxt;
  logic [BIT_IDX_W-1:0] i_r, i_nxt;
  logic [BIT_IDX_W-1:0] bidx_r, bidx_nxt;
  logic [NUM_WIDTH-1:0] a_r, a_nxt;
  logic [NUM_WIDTH-1:0] x_r, x_nxt;
  logic                 fail_r, fail_nxt;
  logic [CNT_WIDTH-1:0] rounds_r, rounds_nxt;
  logic [CNT_WIDTH-1:0] rcount_r, rcount_nxt;
  logic                 comp_r, comp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_pp_r, out_pp_nxt;

  logic                 mm_start;
  logic [NUM_WIDTH-1:0] mm_a;
  mm_rsp_t              mm_rsp;

  logic [NUM_WIDTH-1:0] n_in;
  logic [NUM_WIDTH:0]   div_t;
  logic [NUM_WIDTH:0]   div_m;
  logic [NUM_WIDTH-1:0] n_m1;
  logic [CNT_WIDTH-1:0] limit;
  logic [CNT_WIDTH-1:0] cnt_inc;
  logic [BIT_IDX_W-1:0] i_inc;

  always_comb begin
    n_in    = in_candidate[NUM_WIDTH-1:0];
    n_m1    = n_r - 1'b1;
    div_t   = {rem_r, rnd_r[ridx_r]};
    div_m   = {1'b0, n_r} - (NUM_WIDTH+1)'(3);
    cnt_inc = rcount_r + 1'b1;
    i_inc   = i_r + 1'b1;
    if (rounds_r == '0) begin
      limit = CNT_WIDTH'(1);
    end else if (rounds_r > CNT_WIDTH'(MAX_ROUNDS)) begin
      limit = CNT_WIDTH'(MAX_ROUNDS);
    end else begin
      limit = rounds_r;
    end
  end

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    rnd_nxt       = rnd_r;
    rem_nxt       = rem_r;
    ridx_nxt      = ridx_r;
    d_nxt         = d_r;
    s_nxt         = s_r;
    i_nxt         = i_r;
    bidx_nxt      = bidx_r;
    a_nxt         = a_r;
    x_nxt         = x_r;
    fail_nxt      = fail_r;
    rounds_nxt    = cfg_we ? cfg_wdata : rounds_r;
    rcount_nxt    = rcount_r;
    comp_nxt      = comp_r;
    out_valid_nxt = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    out_pp_nxt    = out_pp_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt    = n_in;
          rnd_nxt  = in_random_value;
          rem_nxt  = '0;
          ridx_nxt = RND_IDX_W'(RND_WIDTH - 1);
          d_nxt    = n_in - 1'b1;
          s_nxt    = '0;
          i_nxt    = BIT_IDX_W'(1);
          if (n_in <= NUM_WIDTH'(1) || n_in == NUM_WIDTH'(4)) begin
            fail_nxt  = 1'b1;
            state_nxt = S_FIN;
          end else if (n_in <= NUM_WIDTH'(3)) begin
            fail_nxt  = 1'b0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt = (div_t >= div_m) ? NUM_WIDTH'(div_t - div_m) : div_t[NUM_WIDTH-1:0];
        if (ridx_r == '0) begin
          state_nxt = S_TZ;
        end else begin
          ridx_nxt = ridx_r - 1'b1;
        end
      end
      S_TZ: begin
        a_nxt = rem_r + NUM_WIDTH'(2);
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + 1'b1;
        end else begin
          x_nxt     = NUM_WIDTH'(1);
          bidx_nxt  = BIT_IDX_W'(NUM_WIDTH - 1);
          state_nxt = S_P_SQ;
        end
      end
      S_P_SQ: state_nxt = S_P_SQW;
      S_P_ML: state_nxt = S_P_MLW;
      S_L_SQ: state_nxt = S_L_SQW;
      S_P_SQW, S_P_MLW: begin
        if (mm_rsp.done) begin
          x_nxt = mm_rsp.prod;
          if (state_r == S_P_SQW && d_r[bidx_r]) begin
            state_nxt = S_P_ML;
          end else if (bidx_r == '0) begin
            state_nxt = S_CHK;
          end else begin
            bidx_nxt  = bidx_r - 1'b1;
            state_nxt = S_P_SQ;
          end
        end
      end
      S_CHK: begin
        if (x_r == NUM_WIDTH'(1) || x_r == n_m1) begin
          fail_nxt  = 1'b0;
          state_nxt = S_FIN;
        end else if (i_r >= s_r) begin
          fail_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_L_SQ;
        end
      end
      S_L_SQW: begin
        if (mm_rsp.done) begin
          x_nxt = mm_rsp.prod;
          i_nxt = i_inc;
          if (mm_rsp.prod == NUM_WIDTH'(1)) begin
            fail_nxt  = 1'b1;
            state_nxt = S_FIN;
          end else if (mm_rsp.prod == n_m1) begin
            fail_nxt  = 1'b0;
            state_nxt = S_FIN;
          end else if (i_inc >= s_r) begin
            fail_nxt  = 1'b1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_L_SQ;
          end
        end
      end
      S_FIN: begin
        if (!(out_valid_r && out_stall)) begin
          state_nxt = S_IDLE;
          if (cnt_inc >= limit) begin
            out_valid_nxt = 1'b1;
            out_pp_nxt    = !(comp_r || fail_r);
            rcount_nxt    = '0;
            comp_nxt      = 1'b0;
          end else begin
            rcount_nxt = cnt_inc;
            comp_nxt   = comp_r || fail_r;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state_r != S_IDLE);
    mm_start = 1'b0;
    mm_a     = x_r;
    unique case (state_r)
      S_P_SQ, S_L_SQ: mm_start = 1'b1;
      S_P_ML: begin
        mm_start = 1'b1;
        mm_a     = a_r;
      end
      default: mm_start = 1'b0;
    endcase
  end

  mrpt_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .op_a    (mm_a),
    .op_b    (x_r),
    .modulus (n_r),
    .rsp     (mm_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rounds_r    <= CNT_WIDTH'(1);
      rcount_r    <= '0;
      comp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rounds_r    <= rounds_nxt;
      rcount_r    <= rcount_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r      <= n_nxt;
    rnd_r    <= rnd_nxt;
    rem_r    <= rem_nxt;
    ridx_r   <= ridx_nxt;
    d_r      <= d_nxt;
    s_r      <= s_nxt;
    i_r      <= i_nxt;
    bidx_r   <= bidx_nxt;
    a_r      <= a_nxt;
    x_r      <= x_nxt;
    fail_r   <= fail_nxt;
    out_pp_r <= out_pp_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_probably_prime = out_pp_r;

`ifndef SYNTHESIS
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("verdict raised outside round finish");
  a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && !out_valid_r |=> rcount_r < CNT_WIDTH'(MAX_ROUNDS))
    else $error("round count ran past limit");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> (state_r == S_P_SQW || state_r == S_P_MLW || state_r == S_L_SQW))
    else $error("multiplier result with no waiting step");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for miller_rabin_primality_test: directed table, random rounds.
module tb_top;
  import mrpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct {
    logic [31:0]          cand;
    logic [RND_WIDTH-1:0] rnd;
    int                   exp_bit;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [31:0]          in_candidate = '0;
  logic [RND_WIDTH-1:0] in_random_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_probably_prime;
  logic                 cfg_we = 1'b0;
  logic [CNT_WIDTH-1:0] cfg_wdata = '0;

  logic [CNT_WIDTH-1:0] rounds_reg;
  int unsigned          group_rounds;
  bit                   group_composite;
  bit                   verdict_q[$];
  int                   typed_q[$];
  int                   errors = 0;
  int                   words_in = 0;
  int                   verdicts = 0;
  int                   idle_cycles = 0;
  bit                   stall_hold = 1'b0;
  stim_row_t            table_rows[$];

  always #1 clk = ~clk;

  miller_rabin_primality_test uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_candidate(in_candidate), .in_random_value(in_random_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_probably_prime(out_probably_prime),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  function automatic longint unsigned mod_mul(longint unsigned x, longint unsigned y,
                                             longint unsigned n);
    return (x * y) % n;
  endfunction

  function automatic bit witness_fails(logic [31:0] cand, logic [RND_WIDTH-1:0] rv);
    longint unsigned n, d, a, x, acc, e, b;
    int unsigned     s;
    n = cand;
    if (n <= 1 || n == 4) return 1'b1;
    if (n <= 3) return 1'b0;
    d = n - 1;
    s = 0;
    while (d[0] == 1'b0) begin
      d = d >> 1;
      s++;
    end
    a = 2 + longint'(rv) % (n - 3);
    acc = 1;
    b = a % n;
    e = d;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, b, n);
      b = mod_mul(b, b, n);
      e = e >> 1;
    end
    x = acc;
    if (x == 1 || x == n - 1) return 1'b0;
    for (int unsigned i = 1; i < s; i++) begin
      x = mod_mul(x, x, n);
      if (x == 1) return 1'b1;
      if (x == n - 1) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned round_limit();
    if (rounds_reg == 0) return 1;
    if (rounds_reg > MAX_ROUNDS) return MAX_ROUNDS;
    return rounds_reg;
  endfunction

  task automatic predict_round(logic [31:0] cand, logic [RND_WIDTH-1:0] rv, int typed);
    if (witness_fails(cand, rv)) group_composite = 1'b1;
    group_rounds++;
    if (group_rounds >= round_limit()) begin
      verdict_q.push_back(!group_composite);
      typed_q.push_back(typed);
      group_rounds = 0;
      group_composite = 1'b0;
    end
  endtask

  task automatic send_word(logic [31:0] cand, logic [RND_WIDTH-1:0] rv, int typed);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_candidate <= cand;
    in_random_value <= rv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_round(cand, rv, typed);
    words_in++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0 || in_stall) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_rounds(logic [CNT_WIDTH-1:0] val);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    rounds_reg = val;
  endtask

  function automatic logic [31:0] pick_candidate();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 40);
      1: return $urandom() | 32'h1;
      2: return $urandom_range(5, 100000) | 32'h1;
      3: return 32'hFFFF_FFFB;
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 2) == 0 || stall_hold) out_stall <= ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 60) == 0) stall_hold <= ~stall_hold;
    if (rst_n && out_valid && !out_stall) begin
      verdicts++;
      if (verdict_q.size() == 0) begin
        $error("unexpected word: probably_prime=%0d", out_probably_prime);
        errors++;
      end else begin
        if (out_probably_prime !== verdict_q[0]) begin
          $error("probably_prime mismatch: expected %0d actual %0d",
                 verdict_q[0], out_probably_prime);
          errors++;
        end
        if (typed_q[0] >= 0 && verdict_q[0] != typed_q[0]) begin
          $error("probably_prime table mismatch: expected %0d predicted %0d",
                 typed_q[0], verdict_q[0]);
          errors++;
        end
        void'(verdict_q.pop_front());
        void'(typed_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("miller_rabin_primality_test regression: fail");
      $finish;
    end
  end

  initial begin
    logic [31:0] c;
    table_rows = '{
      '{32'd0, 31'd0, 0}, '{32'd1, 31'h7FFF_FFFF, 0}, '{32'd2, 31'd5, 1},
      '{32'd3, 31'd0, 1}, '{32'd4, 31'd9, 0}, '{32'd5, 31'd0, -1},
      '{32'd6, 31'd1, -1}, '{32'd561, 31'd0, -1}, '{32'd97, 31'h7FFF_FFFF, -1},
      '{32'd1024, 31'd3, -1}, '{32'hFFFF_FFFB, 31'h5555_5555, -1},
      '{32'hFFFF_FFFF, 31'h2AAA_AAAA, -1}, '{32'h8000_0000, 31'd7, -1},
      '{32'd2047, 31'd0, -1}, '{32'd7919, 31'd12345, -1}
    };
    rounds_reg = 1;
    group_rounds = 0;
    group_composite = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (table_rows[i]) send_word(table_rows[i].cand, table_rows[i].rnd,
                                      table_rows[i].exp_bit);
    drain();
    write_rounds(7'd0);
    send_word(32'd4, 31'd0, 0);
    send_word(32'd3, 31'd0, 1);
    drain();
    write_rounds(7'd127);
    for (int i = 0; i < 64; i++) send_word(32'd2, 31'(i), (i == 63) ? 1 : -1);
    drain();
    write_rounds(7'd3);
    send_word(32'd3, 31'd1, -1);
    send_word(32'd9, 31'd1, -1);
    send_word(32'd2, 31'd1, 0);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      write_rounds(7'($urandom_range(1, 5)));
      for (int i = 0; i < 15; i++) begin
        if (i % int'(round_limit()) == 0) c = pick_candidate();
        if ($urandom_range(0, 9) == 0) c = pick_candidate();
        send_word(c, 31'($urandom()), -1);
        if (i == 7 && ph == 1) drain();
      end
      drain();
    end
    write_rounds(7'd1);
    for (int i = 0; i < 20; i++) send_word(pick_candidate(), 31'($urandom()), -1);
    drain();
    $display("covered %0d rounds and %0d verdicts across rounds settings 0,1,3,127 and random",
             words_in, verdicts);
    if (errors == 0 && verdict_q.size() == 0)
      $display("miller_rabin_primality_test regression: pass");
    else
      $display("miller_rabin_primality_test regression: fail");
    $finish;
  end
endmodule
